@@ sv/stereo_allpass_reverb_chain_defines.svh @@
// Assertion macros for the stereo allpass reverb chain.
// Depends on aclk and aresetn being visible where the macros are used.
`ifndef STEREO_ALLPASS_REVERB_CHAIN_DEFINES_SVH
`define STEREO_ALLPASS_REVERB_CHAIN_DEFINES_SVH
`ifndef ASSERT_OFF
`define SARC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("sarc: assertion failed");
`define SARC_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("sarc: forbidden condition seen");
`else
`define SARC_ASSERT(lbl, prop)
`define SARC_NEVER(lbl, cond)
`endif
`endif

@@ sv/sarc_pkg.sv @@
// Shared types, constants and fixed-point helpers for the allpass reverb chain.
// No dependencies.
package sarc_pkg;

    localparam int unsigned NUM_STAGES     = 3;
    localparam int unsigned DELAY_ZERO_LEN = 1301;
    localparam int unsigned DELAY_ONE_LEN  = 687;
    localparam int unsigned DELAY_TWO_LEN  = 335;
    localparam int unsigned DELAY_LEN [NUM_STAGES] =
        '{DELAY_ZERO_LEN, DELAY_ONE_LEN, DELAY_TWO_LEN};

    // Register stages through one allpass section.
    localparam int unsigned AP_LAT     = 5;
    localparam int unsigned FIFO_DEPTH = 32;
    localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned CFG_IDX_W  = 3;

    typedef logic signed [15:0] sample_t;
    typedef logic [14:0]        gain_t;
    typedef logic [15:0]        level_t;

    localparam gain_t  GAIN_RESET = 15'd22938;
    localparam level_t DRY_RESET  = 16'd0;
    localparam level_t WET_RESET  = 16'd32768;

    typedef struct packed {
        sample_t right;
        sample_t left;
    } stereo_t;

    typedef struct packed {
        logic    valid;
        stereo_t smp;
    } beat_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_ZERO,
        CFG_GAIN_ONE,
        CFG_GAIN_TWO,
        CFG_DRY_LEVEL,
        CFG_WET_LEVEL
    } cfg_reg_t;

    function automatic sample_t sat16(input logic signed [19:0] v);
        if (v > 20'sd32767) begin
            return 16'sh7fff;
        end else if (v < -20'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Q0.15 gain times Q1.15 sample, exact.
    function automatic logic signed [31:0] mul_gain(input gain_t g, input sample_t d);
        logic signed [31:0] a;
        logic signed [31:0] b;
        a = {17'b0, g};
        b = {{16{d[15]}}, d};
        return a * b;
    endfunction

    function automatic logic signed [32:0] mul_level(input level_t l, input sample_t v);
        logic signed [32:0] a;
        logic signed [32:0] b;
        a = {17'b0, l};
        b = {{17{v[15]}}, v};
        return a * b;
    endfunction

    // Round half up, floor shift by 15.
    function automatic logic signed [16:0] rnd_gain(input logic signed [31:0] p);
        logic signed [31:0] t;
        t = p + 32'sd16384;
        return t[31:15];
    endfunction

    function automatic logic signed [18:0] rnd_mix(input logic signed [33:0] s);
        logic signed [33:0] t;
        t = s + 34'sd16384;
        return t[33:15];
    endfunction

    function automatic sample_t sat_add(input sample_t a, input logic signed [16:0] b);
        logic signed [19:0] s;
        s = {{4{a[15]}}, a} + {{3{b[16]}}, b};
        return sat16(s);
    endfunction

    function automatic sample_t sat_sub(input sample_t a, input logic signed [16:0] b);
        logic signed [19:0] s;
        s = {{4{a[15]}}, a} - {{3{b[16]}}, b};
        return sat16(s);
    endfunction

endpackage

@@ sv/stereo_allpass_reverb_chain.sv @@
// Stereo three-section allpass reverb with dry/wet mix and output buffer.
// Depends on sarc_pkg, sarc_ram, sarc_allpass and the assertion macro header.
//
// Usage:
//   s_tdata carries one stereo pair per transfer; m_tdata returns the mixed pair.
//   Registers are written on the cfg channel (index, data); cfg_ready is always
//   high. Write them only while no item is in flight.
//   An input transfer reaches m_tvalid through the three five-stage allpass
//   sections, the registered mix products and the output buffer. Throughput is
//   one pair per cycle while s_tready is high: each delay line is a RAM with
//   one read and one write port, and the section pipelines never stall.
//   A 32-entry output buffer absorbs results while m_tready is low. s_tready
//   is driven by a credit count of items in flight plus items buffered, so
//   up to 32 pairs are taken during a stall before s_tready drops.
//   Reset (aresetn low, synchronous) empties the pipeline and buffer, resets
//   registers and delay pointers. Delay lines read as zero until each has
//   been filled once, so no clearing pass is needed.
`include "stereo_allpass_reverb_chain_defines.svh"
module stereo_allpass_reverb_chain (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [15:0] in_left, [31:16] in_right
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // [15:0] out_left, [31:16] out_right
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sarc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import sarc_pkg::*;

    localparam int unsigned DRY_DEPTH = NUM_STAGES * AP_LAT;

    logic    in_xfer;
    logic    out_xfer;
    gain_t   gain_reg [NUM_STAGES];
    level_t  dry_lvl_reg;
    level_t  wet_lvl_reg;
    beat_t   chain [NUM_STAGES+1];
    stereo_t dry_reg [DRY_DEPTH];

    logic               mix_vld_reg;
    logic signed [32:0] wet_pl_reg, wet_pr_reg, dry_pl_reg, dry_pr_reg;
    stereo_t            mix_smp;

    stereo_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   fifo_cnt_reg, fifo_cnt_next;
    logic [CNT_W-1:0]   credit_reg, credit_next;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                gain_reg[i] <= GAIN_RESET;
            end
            dry_lvl_reg <= DRY_RESET;
            wet_lvl_reg <= WET_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_GAIN_ZERO: gain_reg[0] <= cfg_data[14:0];
                CFG_GAIN_ONE:  gain_reg[1] <= cfg_data[14:0];
                CFG_GAIN_TWO:  gain_reg[2] <= cfg_data[14:0];
                CFG_DRY_LEVEL: dry_lvl_reg <= cfg_data;
                CFG_WET_LEVEL: wet_lvl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Allpass sections
    assign chain[0].valid = in_xfer;
    assign chain[0].smp   = stereo_t'(s_tdata);

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        localparam int unsigned LEN = DELAY_LEN[k];
        localparam int unsigned AW  = (LEN > 1) ? $clog2(LEN) : 1;

        logic [AW-1:0] rd_idx_reg, wr_idx_reg;
        logic          wrap_reg;
        logic          rd_ok_reg;
        stereo_t       ram_q;
        stereo_t       d_val;
        beat_t         w_beat;

        // Write slot trails the read slot by the section's write-back stage s3, so a
        // line length above that depth keeps every read after its write.
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rd_idx_reg <= '0;
                wr_idx_reg <= '0;
                wrap_reg   <= 1'b0;
            end else begin
                if (chain[k].valid) begin
                    if (rd_idx_reg == AW'(LEN - 1)) begin
                        rd_idx_reg <= '0;
                        wrap_reg   <= 1'b1;
                    end else begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                if (w_beat.valid) begin
                    wr_idx_reg <= (wr_idx_reg == AW'(LEN - 1)) ? '0 : wr_idx_reg + 1'b1;
                end
            end
        end

        // Slots not yet written since reset read as zero.
        always_ff @(posedge aclk) begin
            rd_ok_reg <= wrap_reg;
        end

        assign d_val = rd_ok_reg ? ram_q : '0;

        sarc_ram #(
            .DEPTH (LEN),
            .WIDTH ($bits(stereo_t))
        ) u_line (
            .aclk    (aclk),
            .wr_en   (w_beat.valid),
            .wr_addr (wr_idx_reg),
            .wr_data (w_beat.smp),
            .rd_en   (chain[k].valid),
            .rd_addr (rd_idx_reg),
            .rd_data (ram_q)
        );

        sarc_allpass u_ap (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .gain     (gain_reg[k]),
            .in_beat  (chain[k]),
            .rd_data  (d_val),
            .wr_beat  (w_beat),
            .out_beat (chain[k+1])
        );
    end

    // Dry path delay, matched to the three sections
    always_ff @(posedge aclk) begin
        dry_reg[0] <= stereo_t'(s_tdata);
        for (int i = 1; i < DRY_DEPTH; i++) begin
            dry_reg[i] <= dry_reg[i-1];
        end
    end

    // Mix: products registered, then one rounded sum into the buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_vld_reg <= 1'b0;
        end else begin
            mix_vld_reg <= chain[NUM_STAGES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        wet_pl_reg <= mul_level(wet_lvl_reg, chain[NUM_STAGES].smp.left);
        wet_pr_reg <= mul_level(wet_lvl_reg, chain[NUM_STAGES].smp.right);
        dry_pl_reg <= mul_level(dry_lvl_reg, dry_reg[DRY_DEPTH-1].left);
        dry_pr_reg <= mul_level(dry_lvl_reg, dry_reg[DRY_DEPTH-1].right);
    end

    always_comb begin
        logic signed [33:0] sum_l;
        logic signed [33:0] sum_r;
        logic signed [18:0] rl;
        logic signed [18:0] rr;
        sum_l = {wet_pl_reg[32], wet_pl_reg} + {dry_pl_reg[32], dry_pl_reg};
        sum_r = {wet_pr_reg[32], wet_pr_reg} + {dry_pr_reg[32], dry_pr_reg};
        rl    = rnd_mix(sum_l);
        rr    = rnd_mix(sum_r);
        mix_smp.left  = sat16({rl[18], rl});
        mix_smp.right = sat16({rr[18], rr});
    end

    // Output buffer; credits cover every item accepted and not yet transferred out
    always_ff @(posedge aclk) begin
        if (mix_vld_reg) begin
            fifo_mem[wr_ptr_reg] <= mix_smp;
        end
    end

    assign fifo_cnt_next = fifo_cnt_reg + CNT_W'(mix_vld_reg) - CNT_W'(out_xfer);
    assign credit_next   = credit_reg + CNT_W'(in_xfer) - CNT_W'(out_xfer);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            credit_reg   <= '0;
        end else begin
            if (mix_vld_reg) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (out_xfer) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fifo_cnt_reg <= fifo_cnt_next;
            credit_reg   <= credit_next;
        end
    end

    assign s_tready = credit_reg < CNT_W'(FIFO_DEPTH);
    assign m_tvalid = fifo_cnt_reg != '0;
    assign m_tdata  = fifo_mem[rd_ptr_reg];

    `SARC_ASSERT(a_credit_bound, credit_reg <= CNT_W'(FIFO_DEPTH))
    `SARC_ASSERT(a_buffer_within_credit, fifo_cnt_reg <= credit_reg)
    `SARC_NEVER(a_no_write_when_full, mix_vld_reg && (fifo_cnt_reg == CNT_W'(FIFO_DEPTH)))

endmodule

@@ sv/sarc_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module sarc_ram #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned WIDTH = 32,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/sarc_allpass.sv @@
// One stereo Schroeder allpass section, five register stages.
// Depends on sarc_pkg; the delay line RAM and its pointers live in the parent.
module sarc_allpass (
    input  logic              aclk,
    input  logic              aresetn,
    input  sarc_pkg::gain_t   gain,
    input  sarc_pkg::beat_t   in_beat,   // x; delay read issued in the same cycle
    input  sarc_pkg::stereo_t rd_data,   // d, in the cycle after in_beat
    output sarc_pkg::beat_t   wr_beat,   // w to write back to the delay line
    output sarc_pkg::beat_t   out_beat   // y
);
    import sarc_pkg::*;

    logic               s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    stereo_t            s1_x_reg, s2_x_reg;
    stereo_t            s2_d_reg, s3_d_reg, s4_d_reg;
    logic signed [31:0] s2_pl_reg, s2_pr_reg;
    stereo_t            s3_w_reg;
    logic signed [31:0] s4_ql_reg, s4_qr_reg;
    stereo_t            s5_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= in_beat.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_x_reg <= in_beat.smp;

        s2_x_reg  <= s1_x_reg;
        s2_d_reg  <= rd_data;
        s2_pl_reg <= mul_gain(gain, rd_data.left);
        s2_pr_reg <= mul_gain(gain, rd_data.right);

        // w = x + g*d
        s3_d_reg       <= s2_d_reg;
        s3_w_reg.left  <= sat_add(s2_x_reg.left,  rnd_gain(s2_pl_reg));
        s3_w_reg.right <= sat_add(s2_x_reg.right, rnd_gain(s2_pr_reg));

        s4_d_reg  <= s3_d_reg;
        s4_ql_reg <= mul_gain(gain, s3_w_reg.left);
        s4_qr_reg <= mul_gain(gain, s3_w_reg.right);

        // y = d - g*w
        s5_y_reg.left  <= sat_sub(s4_d_reg.left,  rnd_gain(s4_ql_reg));
        s5_y_reg.right <= sat_sub(s4_d_reg.right, rnd_gain(s4_qr_reg));
    end

    assign wr_beat.valid  = s3_vld_reg;
    assign wr_beat.smp    = s3_w_reg;
    assign out_beat.valid = s5_vld_reg;
    assign out_beat.smp   = s5_y_reg;

endmodule
